@@ rtl/scanline_register_table_engine_top_assert.svh @@
// ----------------------------------------------------------------------------
// scanline register table engine assertion macros
// shared property forms for the concurrent checks in the rtl modules
// ----------------------------------------------------------------------------
`ifndef SCANLINE_REGISTER_TABLE_ENGINE_TOP_ASSERT_SVH
`define SCANLINE_REGISTER_TABLE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define SRTE_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRTE_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/srte_pkg.sv @@
// ----------------------------------------------------------------------------
// srte_pkg
// types and constants of the scanline register table engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srte_pkg;

  localparam int VISIBLE_LINES = 160;
  localparam int TOTAL_LINES   = 228;
  localparam int CHANNELS      = 3;
  localparam int TARGET_REGS   = 3;

  localparam int HALF_DEPTH  = CHANNELS * VISIBLE_LINES;
  localparam int TABLE_DEPTH = 2 * HALF_DEPTH;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CHAN_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int MODE_W     = 2;
  localparam int LINE_W     = 8;
  localparam int NEXT_W     = LINE_W + 1;
  localparam int CH_IN_W    = 2;
  localparam int VALUE_W    = 16;
  localparam int OFFSET_W   = 10;
  localparam int MASK_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FLIP  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_ENABLE   = 3'd0,
    CFG_CHAN_MASK    = 3'd1,
    CFG_CHAN0_TARGET = 3'd2,
    CFG_CHAN1_TARGET = 3'd3,
    CFG_CHAN2_TARGET = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              clear_en;
    logic              accept;
    logic              rd_en;
    logic              out_load;
    logic              last;
    logic [CHAN_W-1:0] chan;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                clear_last;
    logic                item_play;
    logic [CHANNELS-1:0] chan_valid;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic bsel,
                                                 input logic [CHAN_W-1:0] chan,
                                                 input logic [LINE_W-1:0] line);
    logic [ADDR_W-1:0] base;
    base = bsel ? ADDR_W'(HALF_DEPTH) : '0;
    return base + ADDR_W'(chan) * ADDR_W'(VISIBLE_LINES) + ADDR_W'(line);
  endfunction

endpackage

@@ rtl/srte_ctrl.sv @@
// ----------------------------------------------------------------------------
// srte_ctrl
// sequencer: clearing pass, item acceptance and per-channel result playback
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "scanline_register_table_engine_top_assert.svh"

module srte_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  output logic                result_valid,
  input  logic                result_stall,
  input  srte_pkg::dp_status_t status,
  output srte_pkg::ctrl_cmd_t  cmd
);
  import srte_pkg::*;

  state_t            state, state_next;
  logic [CHAN_W-1:0] ch, ch_next;
  logic              accept;
  logic              last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  assign item_stall   = (state != ST_IDLE);
  assign result_valid = (state == ST_EMIT);
  assign accept       = item_valid && (state == ST_IDLE);

  // no valid channel above the current one
  always_comb begin
    last = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (i > int'(ch) && status.chan_valid[i]) last = 1'b0;
    end
  end

  always_comb begin
    state_next   = state;
    ch_next      = ch;
    cmd          = '0;
    cmd.chan     = ch;
    cmd.last     = last;
    cmd.accept   = accept;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && status.item_play) begin
          ch_next    = '0;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (status.chan_valid[ch]) begin
          cmd.rd_en  = 1'b1;
          state_next = ST_LOAD;
        end else begin
          ch_next = ch + 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!result_stall) begin
          if (last) begin
            state_next = ST_IDLE;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  `SRTE_ASSERT_IMP(a_no_accept_while_result, clk, rst, result_valid, item_stall, "item accepted with result pending")
  `SRTE_ASSERT_NXT(a_clear_ends_idle, clk, rst, (state == ST_CLEAR) && status.clear_last, state == ST_IDLE, "clearing pass did not end")
  `SRTE_ASSERT_NXT(a_play_starts_scan, clk, rst, accept && status.item_play, (state == ST_READ) && (ch == '0), "playback tick did not start channel scan")

endmodule

@@ rtl/srte_dpath.sv @@
// ----------------------------------------------------------------------------
// srte_dpath
// config registers, line table memory, latched playback state, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "scanline_register_table_engine_top_assert.svh"

module srte_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  srte_pkg::ctrl_cmd_t             cmd,
  output srte_pkg::dp_status_t            status,
  input  logic [srte_pkg::MODE_W-1:0]     mode,
  input  logic [srte_pkg::LINE_W-1:0]     current_line,
  input  logic                            table_select,
  input  logic [srte_pkg::CH_IN_W-1:0]    channel,
  input  logic [srte_pkg::LINE_W-1:0]     entry_line,
  input  logic [srte_pkg::VALUE_W-1:0]    entry_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srte_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [srte_pkg::OFFSET_W-1:0]   reg_offset,
  output logic [srte_pkg::VALUE_W-1:0]    reg_value,
  output logic                            last
);
  import srte_pkg::*;

  logic                run_enable;
  logic [MASK_W-1:0]   chan_valid_mask;
  logic [OFFSET_W-1:0] target_reg [TARGET_REGS];

  logic                write_buffer;
  logic                display_buffer;
  logic                display_active;
  logic [OFFSET_W-1:0] latched_target [CHANNELS];
  logic [CHANNELS-1:0] latched_valid;
  logic [LINE_W-1:0]   tick_line;

  logic [VALUE_W-1:0]  line_table [TABLE_DEPTH];
  logic [VALUE_W-1:0]  rd_data;
  logic [ADDR_W-1:0]   clear_addr;

  logic [NEXT_W-1:0]   next_line;
  logic                is_tick, is_write, is_flip;
  logic                write_ok, latch_line;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [VALUE_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable      <= 1'b0;
      chan_valid_mask <= '0;
      for (int i = 0; i < TARGET_REGS; i++) target_reg[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RUN_ENABLE:   run_enable      <= cfg_data[0];
        CFG_CHAN_MASK:    chan_valid_mask <= cfg_data[MASK_W-1:0];
        CFG_CHAN0_TARGET: target_reg[0]   <= cfg_data[OFFSET_W-1:0];
        CFG_CHAN1_TARGET: target_reg[1]   <= cfg_data[OFFSET_W-1:0];
        CFG_CHAN2_TARGET: target_reg[2]   <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // item decode
  always_comb begin
    next_line = {1'b0, current_line} + 1'b1;
    if (next_line == NEXT_W'(TOTAL_LINES)) next_line = '0;
  end

  assign is_tick    = (mode == MODE_TICK);
  assign is_write   = (mode == MODE_WRITE);
  assign is_flip    = (mode == MODE_FLIP);
  assign write_ok   = is_write && (int'(channel) < CHANNELS)
                      && (int'(entry_line) < VISIBLE_LINES);
  assign latch_line = is_tick && (next_line == NEXT_W'(VISIBLE_LINES));

  assign status.item_play  = is_tick && (next_line < NEXT_W'(VISIBLE_LINES))
                             && display_active && (|latched_valid);
  assign status.chan_valid = latched_valid;
  assign status.clear_last = (clear_addr == ADDR_W'(TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      write_buffer   <= 1'b0;
      display_buffer <= 1'b0;
      display_active <= 1'b0;
      latched_valid  <= '0;
      for (int c = 0; c < CHANNELS; c++) latched_target[c] <= '0;
      clear_addr     <= '0;
    end else begin
      if (cmd.clear_en) clear_addr <= clear_addr + 1'b1;
      if (cmd.accept) begin
        if (is_flip) write_buffer <= ~write_buffer;
        if (latch_line) begin
          if (run_enable) begin
            display_active <= 1'b1;
            display_buffer <= write_buffer;
            for (int c = 0; c < CHANNELS; c++) begin
              if (c < TARGET_REGS) begin
                latched_target[c] <= target_reg[c];
                latched_valid[c]  <= chan_valid_mask[c];
              end else begin
                latched_target[c] <= '0;
                latched_valid[c]  <= 1'b0;
              end
            end
          end else begin
            display_active <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_tick) tick_line <= next_line[LINE_W-1:0];
  end

  // table memory port selection
  always_comb begin
    if (cmd.clear_en) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = cmd.accept && write_ok;
      mem_waddr = tbl_addr(write_buffer ^ table_select, CHAN_W'(channel), entry_line);
      mem_wdata = entry_value;
    end
  end

  assign mem_raddr = tbl_addr(display_buffer, cmd.chan, tick_line);

  always_ff @(posedge clk) begin
    if (mem_we) line_table[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) rd_data <= line_table[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      reg_offset <= latched_target[cmd.chan];
      reg_value  <= rd_data;
      last       <= cmd.last;
    end
  end

  `SRTE_ASSERT_IMP(a_load_after_read, clk, rst, cmd.out_load, $past(cmd.rd_en), "result loaded without table read")

endmodule

@@ rtl/scanline_register_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// scanline_register_table_engine_top
// double-buffered per-scanline register table for three channels
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the 960-entry line table,
// one entry per cycle, and holds item_stall high until the pass ends;
// configuration writes are taken at any time. Table writes and buffer flips
// are accepted in the idle state and may follow back to back, as may line
// ticks with no register writes. A tick that plays back is accepted, then
// each valid channel in turn goes through a table read, a result load and a
// result transaction, and channels that are not valid are skipped; items
// stall until the last valid channel's result is taken. The single read port
// of the table memory serialises the channels.
`timescale 1ns / 1ps

module scanline_register_table_engine_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [srte_pkg::MODE_W-1:0]     mode,
  input  logic [srte_pkg::LINE_W-1:0]     current_line,
  input  logic                            table_select,
  input  logic [srte_pkg::CH_IN_W-1:0]    channel,
  input  logic [srte_pkg::LINE_W-1:0]     entry_line,
  input  logic [srte_pkg::VALUE_W-1:0]    entry_value,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [srte_pkg::OFFSET_W-1:0]   reg_offset,
  output logic [srte_pkg::VALUE_W-1:0]    reg_value,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srte_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srte_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  srte_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  srte_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .mode         (mode),
    .current_line (current_line),
    .table_select (table_select),
    .channel      (channel),
    .entry_line   (entry_line),
    .entry_value  (entry_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .reg_offset   (reg_offset),
    .reg_value    (reg_value),
    .last         (last)
  );

endmodule
